FILE: rtl/pac_pkg.sv
`default_nettype none

package pac_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // instruction opcodes (high nibble of the instruction byte)
    localparam logic [3:0] OP_LDAM = 4'd0;
    localparam logic [3:0] OP_LDBM = 4'd1;
    localparam logic [3:0] OP_STAM = 4'd2;
    localparam logic [3:0] OP_LDAC = 4'd3;
    localparam logic [3:0] OP_LDBC = 4'd4;
    localparam logic [3:0] OP_LDAP = 4'd5;
    localparam logic [3:0] OP_LDAI = 4'd6;
    localparam logic [3:0] OP_LDBI = 4'd7;
    localparam logic [3:0] OP_STAI = 4'd8;
    localparam logic [3:0] OP_BR   = 4'd9;
    localparam logic [3:0] OP_BRZ  = 4'd10;
    localparam logic [3:0] OP_BRN  = 4'd11;
    localparam logic [3:0] OP_RSVD = 4'd12;
    localparam logic [3:0] OP_OPR  = 4'd13;
    localparam logic [3:0] OP_PFIX = 4'd14;
    localparam logic [3:0] OP_NFIX = 4'd15;

    // operations selected by the operand of OPR
    localparam logic [31:0] OPR_BRB = 32'd0;
    localparam logic [31:0] OPR_ADD = 32'd1;
    localparam logic [31:0] OPR_SUB = 32'd2;
    localparam logic [31:0] OPR_SVC = 32'd3;

    // service codes held in A on SVC
    localparam logic [31:0] SVC_EXIT  = 32'd0;
    localparam logic [31:0] SVC_WRITE = 32'd1;
    localparam logic [31:0] SVC_READ  = 32'd2;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_SERVICE = 3'd1;
    localparam logic [2:0] ST_EXITED  = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_BAD_OP  = 3'd4;
    localparam logic [2:0] ST_BAD_OPR = 3'd5;

    // negative prefix fill
    localparam logic [31:0] NFIX_FILL = 32'hFFFFFF00;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] word_address;
        logic [31:0] write_data;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] program_counter;
        logic [31:0] accumulator_a;
        logic [31:0] accumulator_b;
        logic [2:0]  status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_CMD_RD,
        S_FETCH,
        S_DECODE,
        S_EXEC,
        S_MEM,
        S_LOAD
    } t_state;

    // source of the word index sent through the wrap unit
    typedef enum logic [1:0] {
        WSEL_CMD,
        WSEL_PC,
        WSEL_DATA
    } t_wsel;

    typedef struct packed {
        logic       load_in;
        logic       wrap_req;
        t_wsel      wrap_sel;
        logic       mem_we;
        logic       wdata_a;
        logic       mem_re;
        logic       decode;
        logic       exec;
        logic       clr_opnd;
        logic       load_reg;
        logic       rd_cap;
        logic       finish;
        logic [2:0] status;
    } t_ctrl;

    typedef struct packed {
        logic       wrap_done;
        logic [3:0] op;
        logic       opr_ok;
        logic       opr_svc;
        logic       a_exit;
        logic       a_io;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/pac_wrap.sv
`default_nettype none

module pac_wrap #(
    parameter int MEM_WORDS = 65536
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req,
    input  wire logic [31:0]                  i_value,
    output logic                              o_done,
    output logic [$clog2(MEM_WORDS)-1:0]      o_index
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam bit IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            // power-of-two size: the index is the low bits
            assign o_done  = i_req;
            assign o_index = i_value[AW-1:0];
        end else begin : g_recip
            // reciprocal of the size; the quotient estimate is low by at most one
            localparam logic [23:0] RECIP = 24'((64'd1 << 32) / MEM_WORDS);
            localparam logic [AW:0] MODV  = (AW+1)'(MEM_WORDS);

            logic          r_s1;
            logic          r_s2;
            logic          r_fin;
            logic [31:0]   r_val;
            logic [55:0]   r_prod;
            logic [AW:0]   r_diff;
            logic [AW-1:0] r_idx;
            logic          take;
            logic [31:0]   qm;
            logic [31:0]   diff_full;
            logic [AW-1:0] n_idx;

            assign take = i_req && !r_s1 && !r_s2 && !r_fin;

            // remainder estimate below twice the size, then one correction
            always_comb begin
                qm        = {8'h00, r_prod[55:32]} * 32'(MODV);
                diff_full = r_val - qm;
                if (r_diff >= MODV) begin
                    n_idx = AW'(r_diff - MODV);
                end else begin
                    n_idx = r_diff[AW-1:0];
                end
            end

            // three-stage sequence: multiply, subtract, correct
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_s1  <= 1'b0;
                    r_s2  <= 1'b0;
                    r_fin <= 1'b0;
                end else begin
                    r_s1  <= take;
                    r_s2  <= r_s1;
                    r_fin <= r_s2;
                end
            end

            always_ff @(posedge i_clk) begin
                if (take) begin
                    r_val  <= i_value;
                    r_prod <= {24'd0, i_value} * {32'd0, RECIP};
                end
                if (r_s1) begin
                    r_diff <= diff_full[AW:0];
                end
                if (r_s2) begin
                    r_idx <= n_idx;
                end
            end

            assign o_done  = r_fin;
            assign o_index = r_idx;
        end
    endgenerate

endmodule

`default_nettype wire

FILE: rtl/pac_dp.sv
`default_nettype none

module pac_dp #(
    parameter int MEM_WORDS = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pac_pkg::t_in          i_in,
    input  wire pac_pkg::t_ctrl        i_ctrl,
    output pac_pkg::t_dp_status        o_status,
    output pac_pkg::t_out              o_out
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0]     r_mem [MEM_WORDS];
    pac_pkg::t_in    r_in;
    logic [31:0]     r_rdata;
    logic [31:0]     r_pc;
    logic [31:0]     r_a;
    logic [31:0]     r_b;
    logic [31:0]     r_opnd;
    logic [3:0]      r_op;
    logic [31:0]     r_rd;
    logic [2:0]      r_status;

    logic [31:0]     n_pc;
    logic [31:0]     n_a;
    logic [31:0]     n_b;
    logic [31:0]     n_opnd;
    logic [31:0]     data_addr;
    logic [31:0]     wrap_value;
    logic            wrap_done;
    logic [AW-1:0]   mem_idx;
    logic [7:0]      ins_byte;
    logic [31:0]     pc_sum;
    logic            keep_opnd;

    // data word index for memory instructions
    always_comb begin
        if (r_op == pac_pkg::OP_LDAI) begin
            data_addr = {2'b00, r_a[31:2]} + r_opnd;
        end else if (r_op == pac_pkg::OP_LDBI || r_op == pac_pkg::OP_STAI) begin
            data_addr = {2'b00, r_b[31:2]} + r_opnd;
        end else begin
            data_addr = r_opnd;
        end
    end

    // wrap source select
    always_comb begin
        case (i_ctrl.wrap_sel)
            pac_pkg::WSEL_CMD:  wrap_value = {16'h0000, r_in.word_address};
            pac_pkg::WSEL_PC:   wrap_value = {2'b00, r_pc[31:2]};
            pac_pkg::WSEL_DATA: wrap_value = data_addr;
            default:            wrap_value = data_addr;
        endcase
    end

    pac_wrap #(
        .MEM_WORDS (MEM_WORDS)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_ctrl.wrap_req),
        .i_value (wrap_value),
        .o_done  (wrap_done),
        .o_index (mem_idx)
    );

    // single-port word memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mem_we) begin
            r_mem[mem_idx] <= i_ctrl.wdata_a ? r_a : r_in.write_data;
        end
        if (i_ctrl.mem_re) begin
            r_rdata <= r_mem[mem_idx];
        end
    end

    // instruction byte, little-endian within the fetched word
    always_comb begin
        case (r_pc[1:0])
            2'd0:    ins_byte = r_rdata[7:0];
            2'd1:    ins_byte = r_rdata[15:8];
            2'd2:    ins_byte = r_rdata[23:16];
            default: ins_byte = r_rdata[31:24];
        endcase
    end

    assign pc_sum = r_pc + r_opnd;

    // prefixes, bad opcode and bad operation keep the operand
    assign keep_opnd = (r_op == pac_pkg::OP_PFIX) || (r_op == pac_pkg::OP_NFIX)
                    || (r_op == pac_pkg::OP_RSVD)
                    || (r_op == pac_pkg::OP_OPR && r_opnd > pac_pkg::OPR_SVC);

    // register next values
    always_comb begin
        n_pc   = r_pc;
        n_a    = r_a;
        n_b    = r_b;
        n_opnd = r_opnd;
        if (i_ctrl.decode) begin
            n_pc   = r_pc + 32'd1;
            n_opnd = r_opnd | {28'h0000000, ins_byte[3:0]};
        end
        if (i_ctrl.exec) begin
            case (r_op)
                pac_pkg::OP_LDAC: n_a = r_opnd;
                pac_pkg::OP_LDBC: n_b = r_opnd;
                pac_pkg::OP_LDAP: n_a = pc_sum;
                pac_pkg::OP_BR:   n_pc = pc_sum;
                pac_pkg::OP_BRZ: begin
                    if (r_a == 32'd0) begin
                        n_pc = pc_sum;
                    end
                end
                pac_pkg::OP_BRN: begin
                    if (r_a[31]) begin
                        n_pc = pc_sum;
                    end
                end
                pac_pkg::OP_OPR: begin
                    case (r_opnd)
                        pac_pkg::OPR_BRB: n_pc = r_b;
                        pac_pkg::OPR_ADD: n_a = r_a + r_b;
                        pac_pkg::OPR_SUB: n_a = r_a - r_b;
                        default:          n_a = r_a;
                    endcase
                end
                pac_pkg::OP_PFIX: n_opnd = {r_opnd[27:0], 4'h0};
                pac_pkg::OP_NFIX: n_opnd = pac_pkg::NFIX_FILL | {r_opnd[27:0], 4'h0};
                default:          n_a = r_a;
            endcase
            if (!keep_opnd) begin
                n_opnd = '0;
            end
        end
        if (i_ctrl.clr_opnd) begin
            n_opnd = '0;
        end
        if (i_ctrl.load_reg) begin
            if (r_op == pac_pkg::OP_LDBM || r_op == pac_pkg::OP_LDBI) begin
                n_b = r_rdata;
            end else begin
                n_a = r_rdata;
            end
        end
    end

    // architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_opnd   <= '0;
            r_rd     <= '0;
            r_status <= pac_pkg::ST_DONE;
        end else begin
            r_pc   <= n_pc;
            r_a    <= n_a;
            r_b    <= n_b;
            r_opnd <= n_opnd;
            if (i_ctrl.finish) begin
                r_status <= i_ctrl.status;
                r_rd     <= i_ctrl.rd_cap ? r_rdata : 32'd0;
            end
        end
    end

    // transaction latch and opcode
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_in <= i_in;
        end
        if (i_ctrl.decode) begin
            r_op <= ins_byte[7:4];
        end
    end

    assign o_status.wrap_done = wrap_done;
    assign o_status.op        = r_op;
    assign o_status.opr_ok    = r_opnd <= pac_pkg::OPR_SVC;
    assign o_status.opr_svc   = r_opnd == pac_pkg::OPR_SVC;
    assign o_status.a_exit    = r_a == pac_pkg::SVC_EXIT;
    assign o_status.a_io      = (r_a == pac_pkg::SVC_WRITE) || (r_a == pac_pkg::SVC_READ);

    assign o_out.read_data       = r_rd;
    assign o_out.program_counter = r_pc;
    assign o_out.accumulator_a   = r_a;
    assign o_out.accumulator_b   = r_b;
    assign o_out.status          = r_status;

endmodule

`default_nettype wire

FILE: rtl/pac_ctrl.sv
`default_nettype none

module pac_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            i_command,
    input  wire pac_pkg::t_dp_status   i_status,
    output pac_pkg::t_ctrl             o_ctrl,
    output logic                       busy,
    output logic                       o_strobe
);

    pac_pkg::t_state r_state;
    pac_pkg::t_state n_state;
    logic [1:0]      r_cmd;
    logic [1:0]      n_cmd;
    logic            r_halted;
    logic            n_halted;
    logic            r_strobe;

    // state, command, halt and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pac_pkg::S_IDLE;
            r_cmd    <= pac_pkg::CMD_WRITE;
            r_halted <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_halted <= n_halted;
            r_strobe <= o_ctrl.finish;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_halted = r_halted;
        o_ctrl   = '0;
        unique case (r_state)
            pac_pkg::S_IDLE: begin
                if (start) begin
                    o_ctrl.load_in = 1'b1;
                    n_cmd          = i_command;
                    unique case (i_command)
                        pac_pkg::CMD_WRITE, pac_pkg::CMD_READ: begin
                            n_state = pac_pkg::S_CMD;
                        end
                        pac_pkg::CMD_EXEC: begin
                            if (r_halted) begin
                                o_ctrl.finish = 1'b1;
                                o_ctrl.status = pac_pkg::ST_REFUSED;
                            end else begin
                                n_state = pac_pkg::S_FETCH;
                            end
                        end
                        default: begin
                            o_ctrl.finish = 1'b1;
                            o_ctrl.status = pac_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            pac_pkg::S_CMD: begin
                o_ctrl.wrap_req = 1'b1;
                o_ctrl.wrap_sel = pac_pkg::WSEL_CMD;
                if (i_status.wrap_done) begin
                    if (r_cmd == pac_pkg::CMD_WRITE) begin
                        o_ctrl.mem_we = 1'b1;
                        o_ctrl.finish = 1'b1;
                        o_ctrl.status = pac_pkg::ST_DONE;
                        n_state       = pac_pkg::S_IDLE;
                    end else begin
                        o_ctrl.mem_re = 1'b1;
                        n_state       = pac_pkg::S_CMD_RD;
                    end
                end
            end
            pac_pkg::S_CMD_RD: begin
                o_ctrl.rd_cap = 1'b1;
                o_ctrl.finish = 1'b1;
                o_ctrl.status = pac_pkg::ST_DONE;
                n_state       = pac_pkg::S_IDLE;
            end
            pac_pkg::S_FETCH: begin
                o_ctrl.wrap_req = 1'b1;
                o_ctrl.wrap_sel = pac_pkg::WSEL_PC;
                if (i_status.wrap_done) begin
                    o_ctrl.mem_re = 1'b1;
                    n_state       = pac_pkg::S_DECODE;
                end
            end
            pac_pkg::S_DECODE: begin
                o_ctrl.decode = 1'b1;
                n_state       = pac_pkg::S_EXEC;
            end
            pac_pkg::S_EXEC: begin
                unique case (i_status.op) inside
                    pac_pkg::OP_LDAM, pac_pkg::OP_LDBM, pac_pkg::OP_STAM,
                    pac_pkg::OP_LDAI, pac_pkg::OP_LDBI, pac_pkg::OP_STAI: begin
                        n_state = pac_pkg::S_MEM;
                    end
                    pac_pkg::OP_OPR: begin
                        o_ctrl.exec   = 1'b1;
                        o_ctrl.finish = 1'b1;
                        n_state       = pac_pkg::S_IDLE;
                        if (!i_status.opr_ok) begin
                            o_ctrl.status = pac_pkg::ST_BAD_OPR;
                            n_halted      = 1'b1;
                        end else if (!i_status.opr_svc) begin
                            o_ctrl.status = pac_pkg::ST_DONE;
                        end else if (i_status.a_exit) begin
                            o_ctrl.status = pac_pkg::ST_EXITED;
                            n_halted      = 1'b1;
                        end else if (i_status.a_io) begin
                            o_ctrl.status = pac_pkg::ST_SERVICE;
                        end else begin
                            o_ctrl.status = pac_pkg::ST_BAD_OPR;
                            n_halted      = 1'b1;
                        end
                    end
                    pac_pkg::OP_LDAC, pac_pkg::OP_LDBC, pac_pkg::OP_LDAP,
                    pac_pkg::OP_BR, pac_pkg::OP_BRZ, pac_pkg::OP_BRN,
                    pac_pkg::OP_PFIX, pac_pkg::OP_NFIX: begin
                        o_ctrl.exec   = 1'b1;
                        o_ctrl.finish = 1'b1;
                        o_ctrl.status = pac_pkg::ST_DONE;
                        n_state       = pac_pkg::S_IDLE;
                    end
                    default: begin
                        // undefined opcode halts
                        o_ctrl.exec   = 1'b1;
                        o_ctrl.finish = 1'b1;
                        o_ctrl.status = pac_pkg::ST_BAD_OP;
                        n_halted      = 1'b1;
                        n_state       = pac_pkg::S_IDLE;
                    end
                endcase
            end
            pac_pkg::S_MEM: begin
                o_ctrl.wrap_req = 1'b1;
                o_ctrl.wrap_sel = pac_pkg::WSEL_DATA;
                if (i_status.wrap_done) begin
                    o_ctrl.clr_opnd = 1'b1;
                    if (i_status.op == pac_pkg::OP_STAM || i_status.op == pac_pkg::OP_STAI)
                    begin
                        o_ctrl.mem_we  = 1'b1;
                        o_ctrl.wdata_a = 1'b1;
                        o_ctrl.finish  = 1'b1;
                        o_ctrl.status  = pac_pkg::ST_DONE;
                        n_state        = pac_pkg::S_IDLE;
                    end else begin
                        o_ctrl.mem_re = 1'b1;
                        n_state       = pac_pkg::S_LOAD;
                    end
                end
            end
            pac_pkg::S_LOAD: begin
                o_ctrl.load_reg = 1'b1;
                o_ctrl.finish   = 1'b1;
                o_ctrl.status   = pac_pkg::ST_DONE;
                n_state         = pac_pkg::S_IDLE;
            end
            default: begin
                n_state = pac_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = r_state != pac_pkg::S_IDLE;
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

FILE: rtl/prefix_accumulator_cpu_core_unit.sv
`default_nettype none
// Accumulator processor with a private word memory, driven by commands.
// Input channel: a command transaction (command, word_address, write_data)
// is taken at a clock edge where start is high and busy is low.
// Output channel: one result transaction per command, shown on o_out for
// exactly one cycle while o_strobe is high; the receiver cannot stall it,
// and the next command may be taken in that same strobe cycle.
// A command is taken only while busy is low, so each command finishes
// before the next one is taken.
// The single memory port serves fetch, then data access, one after the
// other, and each word index goes through the wrap unit first: a mask for
// a power-of-two size, otherwise a reciprocal multiply, a subtract and one
// correction step, each registered, ahead of every memory access.
// Reset clears pc, A, B, the operand register and the halt flag; memory
// contents are undefined until written. A service request reports status
// 1 and leaves the code in A; the host does the I/O with memory commands.
// Exit, a bad opcode or a bad operation halts the core until reset.
module prefix_accumulator_cpu_core_unit #(
    parameter int MEM_WORDS = 65536
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire pac_pkg::t_in    i_in,
    output logic                 o_strobe,
    output pac_pkg::t_out        o_out
);

    pac_pkg::t_ctrl      ctrl;
    pac_pkg::t_dp_status dp_status;

    pac_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_in.command),
        .i_status  (dp_status),
        .o_ctrl    (ctrl),
        .busy      (busy),
        .o_strobe  (o_strobe)
    );

    pac_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_ctrl   (ctrl),
        .o_status (dp_status),
        .o_out    (o_out)
    );

    // a result only appears while idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // one result per accepted transaction
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !(start && !busy) |=> !o_strobe)
        else $error("result strobe without a transaction");

    // a refused step leaves the program counter alone
    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out.status == pac_pkg::ST_REFUSED
        |-> o_out.program_counter == $past(o_out.program_counter))
        else $error("refused step changed pc");

    // read data only comes with a plain done status
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out.status != pac_pkg::ST_DONE |-> o_out.read_data == 32'd0)
        else $error("read data on a non-done result");

endmodule

`default_nettype wire

FILE: tb/pac_core_checker.sv
`default_nettype none

// watches both channels of the core, predicts every result and compares
module pac_core_checker #(
    parameter int MEM_WORDS = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_busy,
    input  wire pac_pkg::t_in   i_in,
    input  wire logic           i_strobe,
    input  wire pac_pkg::t_out  i_out,
    output int                  o_fail_count,
    output int                  o_pending
);

    import pac_pkg::*;

    // predicted architectural state
    logic [31:0] mem_img [MEM_WORDS];
    logic [31:0] pc_r;
    logic [31:0] a_r;
    logic [31:0] b_r;
    logic [31:0] opnd_r;
    logic        halted_r;

    // results predicted but not yet seen on the output channel
    t_out        core_state_q [$];
    t_out        want;
    int          fail_n = 0;
    int          pending_n = 0;

    assign o_fail_count = fail_n;
    assign o_pending    = pending_n;

    // word index wrap to the memory size
    function automatic logic [31:0] widx(input logic [31:0] w);
        return w % MEM_WORDS;
    endfunction

    // fetch and execute one instruction, returns the status code
    function automatic logic [2:0] execute_insn();
        logic [31:0] word;
        logic [7:0]  insn;
        logic [3:0]  op;
        word   = mem_img[widx(pc_r >> 2)];
        insn   = word[{pc_r[1:0], 3'b000} +: 8];
        op     = insn[7:4];
        pc_r   = pc_r + 32'd1;
        opnd_r = opnd_r | {28'd0, insn[3:0]};
        case (op)
            OP_LDAM: a_r = mem_img[widx(opnd_r)];
            OP_LDBM: b_r = mem_img[widx(opnd_r)];
            OP_STAM: mem_img[widx(opnd_r)] = a_r;
            OP_LDAC: a_r = opnd_r;
            OP_LDBC: b_r = opnd_r;
            OP_LDAP: a_r = pc_r + opnd_r;
            OP_LDAI: a_r = mem_img[widx((a_r >> 2) + opnd_r)];
            OP_LDBI: b_r = mem_img[widx((b_r >> 2) + opnd_r)];
            OP_STAI: mem_img[widx((b_r >> 2) + opnd_r)] = a_r;
            OP_BR:   pc_r = pc_r + opnd_r;
            OP_BRZ:  if (a_r == 32'd0) pc_r = pc_r + opnd_r;
            OP_BRN:  if (a_r[31]) pc_r = pc_r + opnd_r;
            OP_OPR: begin
                case (opnd_r)
                    OPR_BRB: pc_r = b_r;
                    OPR_ADD: a_r = a_r + b_r;
                    OPR_SUB: a_r = a_r - b_r;
                    OPR_SVC: begin
                        // service call: the code in A picks exit, io or error
                        opnd_r = '0;
                        if (a_r == SVC_EXIT) begin
                            halted_r = 1'b1;
                            return ST_EXITED;
                        end
                        if (a_r == SVC_WRITE || a_r == SVC_READ) return ST_SERVICE;
                        halted_r = 1'b1;
                        return ST_BAD_OPR;
                    end
                    default: begin
                        // unknown operation keeps the operand register
                        halted_r = 1'b1;
                        return ST_BAD_OPR;
                    end
                endcase
            end
            OP_PFIX: begin
                opnd_r = opnd_r << 4;
                return ST_DONE;
            end
            OP_NFIX: begin
                opnd_r = NFIX_FILL | (opnd_r << 4);
                return ST_DONE;
            end
            default: begin
                halted_r = 1'b1;
                return ST_BAD_OP;
            end
        endcase
        opnd_r = '0;
        return ST_DONE;
    endfunction

    // apply one command transaction and build its result
    function automatic t_out run_command(input t_in cmd);
        t_out res;
        res = '0;
        case (cmd.command)
            CMD_WRITE: mem_img[widx({16'd0, cmd.word_address})] = cmd.write_data;
            CMD_READ:  res.read_data = mem_img[widx({16'd0, cmd.word_address})];
            CMD_EXEC:  res.status = halted_r ? ST_REFUSED : execute_insn();
            default: ;
        endcase
        res.program_counter = pc_r;
        res.accumulator_a   = a_r;
        res.accumulator_b   = b_r;
        return res;
    endfunction

    // compare results first, then record the transaction taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pc_r     = '0;
            a_r      = '0;
            b_r      = '0;
            opnd_r   = '0;
            halted_r = 1'b0;
            core_state_q.delete();
        end else begin
            if (i_strobe !== 1'b0) begin
                if (core_state_q.size() == 0) begin
                    if (fail_n < 10) begin
                        $display("unexpected result at %0t: pc %h a %h b %h st %0d",
                                 $realtime, i_out.program_counter, i_out.accumulator_a,
                                 i_out.accumulator_b, i_out.status);
                    end
                    fail_n = fail_n + 1;
                end else begin
                    want = core_state_q.pop_front();
                    if (i_out.read_data !== want.read_data ||
                        i_out.program_counter !== want.program_counter ||
                        i_out.accumulator_a !== want.accumulator_a ||
                        i_out.accumulator_b !== want.accumulator_b ||
                        i_out.status !== want.status) begin
                        if (fail_n < 10) begin
                            $display("mismatch at %0t (exp/got): rd %h/%h pc %h/%h",
                                     $realtime, want.read_data, i_out.read_data,
                                     want.program_counter, i_out.program_counter);
                            $display("    a %h/%h b %h/%h st %0d/%0d",
                                     want.accumulator_a, i_out.accumulator_a,
                                     want.accumulator_b, i_out.accumulator_b,
                                     want.status, i_out.status);
                        end
                        fail_n = fail_n + 1;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                core_state_q.push_back(run_command(i_in));
            end
        end
        pending_n = core_state_q.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

    import pac_pkg::*;

    localparam int MEM_WORDS      = 65536;
    localparam int RANDOM_ITEMS   = 950;
    localparam int QUIET_FROM     = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int BOOT_WORDS     = 8;
    localparam int BOOT_STEPS     = 24;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [3:0] OP_UNDEF   = 4'd12;

    // opening program: arithmetic, prefixes, loads, stores, every branch
    // kind and a service call; undefined bytes sit only where a taken
    // branch skips them
    localparam logic [255:0] BOOT_PROG = {
        32'h0000D331, 32'hC0C0D04C, 32'hE1C0B13F, 32'hF0C0A130,
        32'hC0C09250, 32'h80714463, 32'h1E0F2FE7, 32'hD2D1413F
    };

    typedef enum logic [1:0] {
        HALT_EXIT,
        HALT_BAD_SVC,
        HALT_BAD_OPR,
        HALT_BAD_OP
    } halt_kind_e;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_in         i_in    = '0;
    logic        o_strobe;
    t_out        o_out;

    int          fail_count;
    int          pending;
    int          stall_cycles = 0;
    int          n_issued = 0;
    bit          gaps_on = 1'b0;

    // memory words that a write command has set
    bit          written [MEM_WORDS];

    // what the stimulus knows of the core after the last instruction
    logic [31:0] pc_now   = '0;
    logic [31:0] a_now    = '0;
    logic [31:0] b_now    = '0;
    logic [31:0] opnd_now = '0;

    always #1 i_clk = ~i_clk;

    prefix_accumulator_cpu_core_unit #(
        .MEM_WORDS (MEM_WORDS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    pac_core_checker #(
        .MEM_WORDS (MEM_WORDS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in         (i_in),
        .i_strobe     (o_strobe),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe === 1'b1 || (start && busy === 1'b0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one command transaction, with an optional gap before it
    task automatic issue(input logic [1:0] cmd, input logic [15:0] addr,
                         input logic [31:0] data);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= {cmd, addr, data};
        do @(posedge i_clk); while (busy !== 1'b0);
        if (cmd == CMD_WRITE) written[addr] = 1'b1;
        if (cmd != CMD_UNUSED) n_issued++;
    endtask

    // write a word first if it has never been set
    task automatic ensure_written(input logic [31:0] idx);
        logic [15:0] w;
        w = 16'(idx % MEM_WORDS);
        if (!written[w]) issue(CMD_WRITE, w, $urandom);
    endtask

    // execute one instruction and pick up where the core went
    task automatic execute();
        issue(CMD_EXEC, 16'($urandom), $urandom);
        start <= 1'b0;
        do @(posedge i_clk); while (o_strobe !== 1'b1);
        pc_now = o_out.program_counter;
        a_now  = o_out.accumulator_a;
        b_now  = o_out.accumulator_b;
    endtask

    // plant an instruction byte at pc with random neighbors, then run it
    task automatic run_insn(input logic [3:0] op, input logic [3:0] nib);
        logic [31:0] word;
        logic [31:0] opnd;
        opnd = opnd_now | {28'd0, nib};
        word = $urandom;
        // a load only reads a word that was set
        case (op)
            OP_LDAM, OP_LDBM: ensure_written(opnd);
            OP_LDAI:          ensure_written((a_now >> 2) + opnd);
            OP_LDBI:          ensure_written((b_now >> 2) + opnd);
            default: ;
        endcase
        word[{pc_now[1:0], 3'b000} +: 8] = {op, nib};
        issue(CMD_WRITE, pc_now[17:2], word);
        execute();
        case (op)
            OP_PFIX: opnd_now = opnd << 4;
            OP_NFIX: opnd_now = NFIX_FILL | (opnd << 4);
            default: opnd_now = '0;
        endcase
    endtask

    initial begin
        int          pick;
        logic [3:0]  op;
        logic [15:0] addr;
        halt_kind_e  halt_kind;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: data extremes, unused code, then the opening program
        issue(CMD_WRITE, 16'hFFFF, 32'hFFFFFFFF);
        issue(CMD_READ, 16'hFFFF, 32'h0);
        issue(CMD_WRITE, 16'h8000, 32'h0);
        issue(CMD_READ, 16'h8000, 32'hFFFFFFFF);
        issue(CMD_UNUSED, 16'($urandom), $urandom);
        for (int w = 0; w < BOOT_WORDS; w++) begin
            issue(CMD_WRITE, w[15:0], BOOT_PROG[w * 32 +: 32]);
        end
        // data words the opening program loads; word 15 points the indexed
        // load back into the program
        issue(CMD_WRITE, 16'd14, $urandom);
        issue(CMD_WRITE, 16'd15, 32'h00000010);
        repeat (BOOT_STEPS) execute();
        opnd_now = '0;

        // random: mostly well-formed instruction streams, some memory traffic
        n_issued = 0;
        gaps_on  = 1'b1;
        while (n_issued < RANDOM_ITEMS) begin
            if (n_issued >= QUIET_FROM) begin
                gaps_on = 1'b0;
            end else if ($urandom_range(0, 31) == 0) begin
                gaps_on = !gaps_on;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                issue(CMD_WRITE, 16'($urandom), $urandom);
            end else if (pick < 11) begin
                addr = 16'($urandom);
                ensure_written({16'd0, addr});
                issue(CMD_READ, addr, $urandom);
            end else if (pick < 12) begin
                issue(CMD_UNUSED, 16'($urandom), $urandom);
            end else if (pick < 30) begin
                run_insn($urandom_range(0, 1) ? OP_PFIX : OP_NFIX, 4'($urandom));
            end else if (pick < 38) begin
                // service call only with an io code in A and a clear operand
                if (opnd_now == '0 && (a_now == SVC_WRITE || a_now == SVC_READ)) begin
                    run_insn(OP_OPR, OPR_SVC[3:0]);
                end else begin
                    run_insn(OP_LDAC, 4'($urandom_range(SVC_WRITE, SVC_READ)));
                end
            end else begin
                op = 4'($urandom_range(OP_LDAM, OP_UNDEF));
                if (op == OP_UNDEF) op = OP_OPR;
                if (op == OP_OPR && opnd_now != '0) op = OP_LDBC;
                if (op == OP_OPR) begin
                    run_insn(op, 4'($urandom_range(OPR_BRB, OPR_SUB)));
                end else begin
                    run_insn(op, 4'($urandom));
                end
            end
        end

        // one way of halting, then steps and memory traffic while halted
        halt_kind = halt_kind_e'($urandom_range(0, 3));
        case (halt_kind)
            HALT_EXIT: begin
                run_insn(OP_LDBC, 4'($urandom));
                run_insn(OP_LDAC, SVC_EXIT[3:0]);
                run_insn(OP_OPR, OPR_SVC[3:0]);
            end
            HALT_BAD_SVC: begin
                run_insn(OP_LDBC, 4'($urandom));
                run_insn(OP_LDAC, 4'($urandom_range(SVC_READ + 1, 4'hF)));
                run_insn(OP_OPR, OPR_SVC[3:0]);
            end
            HALT_BAD_OPR: run_insn(OP_OPR, 4'($urandom_range(OPR_SVC + 1, 4'hF)));
            default: run_insn(OP_UNDEF, 4'($urandom));
        endcase
        repeat (3) execute();
        issue(CMD_WRITE, 16'($urandom), $urandom);
        addr = 16'($urandom);
        ensure_written({16'd0, addr});
        issue(CMD_READ, addr, $urandom);
        start <= 1'b0;

        // drain and give the verdict
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
